// ----- src/bpl_pkg.sv -----
// Shared types and constants for the BSP point locate block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bpl_pkg;

  localparam int NodeIdxW = 13;
  localparam int NormalW  = 16;
  localparam int CoordW   = 32;
  localparam int StatusW  = 2;
  localparam int LevelsW  = 7;

  // Action codes of an input word.
  localparam logic ActWrite  = 1'b0;
  localparam logic ActLocate = 1'b1;

  // Status codes of a result word.
  localparam logic [StatusW-1:0] StLeaf    = 2'd0;
  localparam logic [StatusW-1:0] StWritten = 2'd1;
  localparam logic [StatusW-1:0] StDepth   = 2'd2;

  typedef struct packed {
    logic                       action;
    logic [NodeIdxW-1:0]        node_index;
    logic                       is_leaf;
    logic signed [NormalW-1:0]  normal_x;
    logic signed [NormalW-1:0]  normal_y;
    logic signed [NormalW-1:0]  normal_z;
    logic signed [CoordW-1:0]   plane_dist;
    logic [NodeIdxW-1:0]        front_child;
    logic [NodeIdxW-1:0]        back_child;
    logic signed [CoordW-1:0]   point_x;
    logic signed [CoordW-1:0]   point_y;
    logic signed [CoordW-1:0]   point_z;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [NodeIdxW-1:0] leaf_index;
    logic [LevelsW-1:0]  levels_walked;
  } out_word_t;

  // One tree node as it sits in the node memory.
  typedef struct packed {
    logic                       is_leaf;
    logic [NodeIdxW-1:0]        back_child;
    logic [NodeIdxW-1:0]        front_child;
    logic signed [CoordW-1:0]   plane_dist;
    logic signed [NormalW-1:0]  normal_z;
    logic signed [NormalW-1:0]  normal_y;
    logic signed [NormalW-1:0]  normal_x;
  } node_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

endpackage

`default_nettype wire

// ----- src/bpl_plane_eval.sv -----
// Three-stage plane side test: sign of normal . point - distance.
// Depends on bpl_pkg for the node and point types.
`default_nettype none

module bpl_plane_eval (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bpl_pkg::node_t  node_i,
  input  bpl_pkg::point_t point_i,
  output logic            done_o,
  output logic            front_o
);

  localparam int ProdW = bpl_pkg::NormalW + bpl_pkg::CoordW;
  localparam int DistW = bpl_pkg::CoordW + 15;
  localparam int SumW  = ProdW + 2;

  logic signed [ProdW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [DistW-1:0] dist_q;
  logic signed [SumW-1:0]  sum_a_q, sum_b_q;
  logic signed [SumW-1:0]  total;
  logic                    v1_q, v2_q, done_q, front_q;

  assign total = sum_a_q + sum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= ProdW'($signed(node_i.normal_x) * $signed(point_i.x));
    prod_y_q <= ProdW'($signed(node_i.normal_y) * $signed(point_i.y));
    prod_z_q <= ProdW'($signed(node_i.normal_z) * $signed(point_i.z));
    dist_q   <= $signed({node_i.plane_dist, 15'd0});
    sum_a_q  <= SumW'(prod_x_q) + SumW'(prod_y_q);
    sum_b_q  <= SumW'(prod_z_q) - SumW'(dist_q);
    front_q  <= !total[SumW-1];
  end

  assign done_o  = done_q;
  assign front_o = front_q;

endmodule

`default_nettype wire

// ----- src/bsp_point_locate_unit.sv -----
// Top level of the BSP point locate block: node memory, walk sequencer, result register.
// Depends on bpl_pkg and bpl_plane_eval.
//
// Usage: one input channel (in_valid_i, in_stall_o, in_word_i) carries words that either
// write one tree node (action 0) or locate a point (action 1). One output channel
// (out_valid_o, out_stall_i, out_word_o) returns exactly one result word per input word,
// in order. A word moves at a rising edge where valid is high and stall is low.
// The result word of a node write appears in the next cycle.
// A query walks the tree from node 0. Each inner node passes through a read of the
// node memory, the three stages of the plane evaluation and a step that maps the chosen
// child into the memory and issues the next read. The block takes no new word while a
// walk is in progress; a new word can be accepted in the cycle in which the result word
// appears, unless the output stalls it.
// The walk stops at a leaf (status 0) or after MAX_DEPTH inner nodes (status 2).
// Node and child indices are reduced modulo NODE_COUNT.
// Reset clears the sequencer state and the result valid flag; the node memory is not cleared,
// and a query must only reach nodes written since reset.
// A stalled result word holds; a new word is accepted only when the result register
// is empty or being taken in the same cycle.
`default_nettype none

module bsp_point_locate_unit #(
  parameter int NODE_COUNT = 8192,
  parameter int MAX_DEPTH  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpl_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpl_pkg::out_word_t  out_word_o
);

  localparam int IdxW   = $clog2(NODE_COUNT);
  localparam int WalkW  = $clog2(MAX_DEPTH + 1);
  localparam int NiW    = bpl_pkg::NodeIdxW;
  // Index reduction by a constant reciprocal; exact for every 13-bit index.
  localparam int SlotSh = NiW + IdxW;
  localparam longint unsigned SlotRcp =
      ((64'd1 << SlotSh) + NODE_COUNT - 1) / NODE_COUNT;
  localparam int ProdW  = 2 * NiW + 2;
  localparam int LvlMax = 2 ** bpl_pkg::LevelsW - 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_NEXT = 2'd3;

  function automatic logic [IdxW-1:0] slot_of(input logic [NiW-1:0] idx);
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] quo;
    logic [ProdW-1:0] rem;
    prod = ProdW'(idx) * ProdW'(SlotRcp);
    quo  = prod >> SlotSh;
    rem  = ProdW'(idx) - quo * ProdW'(NODE_COUNT);
    return rem[IdxW-1:0];
  endfunction

  logic [1:0]             state_q, state_d;
  logic [IdxW-1:0]        node_q, node_d;
  logic [WalkW-1:0]       walked_q, walked_d;
  logic [NiW-1:0]         child_q, child_d;
  bpl_pkg::point_t        point_q;
  logic                   out_valid_q, out_valid_d;
  bpl_pkg::out_word_t     out_word_q, out_word_d;

  logic                   in_acc, out_free, is_write;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        wr_addr, rd_addr, next_slot;
  bpl_pkg::node_t         wr_node, node_rd_q;
  logic                   eval_start, eval_done, eval_front;
  logic [bpl_pkg::LevelsW-1:0] levels;

  // Node memory: one write port for node words, one read port for the walk.
  bpl_pkg::node_t node_mem [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[wr_addr] <= wr_node;
    end
    if (mem_re) begin
      node_rd_q <= node_mem[rd_addr];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_write   = (in_word_i.action == bpl_pkg::ActWrite);

  assign wr_addr = slot_of(in_word_i.node_index);
  always_comb begin
    wr_node.is_leaf     = in_word_i.is_leaf;
    wr_node.back_child  = in_word_i.back_child;
    wr_node.front_child = in_word_i.front_child;
    wr_node.plane_dist  = in_word_i.plane_dist;
    wr_node.normal_z    = in_word_i.normal_z;
    wr_node.normal_y    = in_word_i.normal_y;
    wr_node.normal_x    = in_word_i.normal_x;
  end

  // Writes only happen at a write word; reads only at a query start or in S_NEXT,
  // so the two ports never touch the same cycle.
  assign next_slot = slot_of(child_q);
  assign mem_we    = in_acc && is_write;
  assign mem_re    = (in_acc && !is_write) || (state_q == S_NEXT);
  assign rd_addr   = (state_q == S_NEXT) ? next_slot : '0;

  assign eval_start = (state_q == S_LOOK) && !node_rd_q.is_leaf &&
                      (walked_q != WalkW'(MAX_DEPTH));

  bpl_plane_eval u_plane_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (eval_start),
    .node_i  (node_rd_q),
    .point_i (point_q),
    .done_o  (eval_done),
    .front_o (eval_front)
  );

  always_comb begin
    if (int'(walked_q) > LvlMax) begin
      levels = '1;
    end else begin
      levels = bpl_pkg::LevelsW'(walked_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    walked_d    = walked_q;
    child_d     = child_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (is_write) begin
            out_valid_d              = 1'b1;
            out_word_d.status        = bpl_pkg::StWritten;
            out_word_d.leaf_index    = '0;
            out_word_d.levels_walked = '0;
          end else begin
            node_d   = '0;
            walked_d = '0;
            state_d  = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (node_rd_q.is_leaf || (walked_q == WalkW'(MAX_DEPTH))) begin
          // The walk ends here; wait only if a result is still held.
          if (out_free) begin
            out_valid_d              = 1'b1;
            out_word_d.levels_walked = levels;
            if (node_rd_q.is_leaf) begin
              out_word_d.status     = bpl_pkg::StLeaf;
              out_word_d.leaf_index = NiW'(node_q);
            end else begin
              out_word_d.status     = bpl_pkg::StDepth;
              out_word_d.leaf_index = '0;
            end
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (eval_done) begin
          child_d = eval_front ? node_rd_q.front_child : node_rd_q.back_child;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        node_d   = next_slot;
        walked_d = walked_q + WalkW'(1);
        state_d  = S_LOOK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    walked_q   <= walked_d;
    child_q    <= child_d;
    out_word_q <= out_word_d;
    if (in_acc && !is_write) begin
      point_q.x <= in_word_i.point_x;
      point_q.y <= in_word_i.point_y;
      point_q.z <= in_word_i.point_z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

// ----- src/bpl_checker.sv -----
// Port-level checks for the BSP point locate block, bound to its top level.
// Depends on bpl_pkg and bsp_point_locate_unit.
`default_nettype none

module bpl_checker #(
  parameter int MAX_DEPTH = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input bpl_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bpl_pkg::out_word_t out_word_o
);

  localparam int DepthLvl = (MAX_DEPTH > 127) ? 127 : MAX_DEPTH;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A held result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A node write is answered in the next cycle.
  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.action == bpl_pkg::ActWrite) |=>
      out_valid_o && (out_word_o.status == bpl_pkg::StWritten))
    else $error("node write not answered in the next cycle");

  // A query needs at least one memory read, so no result follows it at once.
  a_query_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.action == bpl_pkg::ActLocate) |=> !out_valid_o)
    else $error("query answered without a node read");

  // Only a found leaf carries an index, and a write walks no levels.
  a_leaf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != bpl_pkg::StLeaf) |->
      (out_word_o.leaf_index == '0) &&
      ((out_word_o.status != bpl_pkg::StWritten) || (out_word_o.levels_walked == '0)))
    else $error("leaf index or level count set where it must be zero");

  // The depth cap reports exactly the cap.
  a_depth_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == bpl_pkg::StDepth) |->
      (out_word_o.levels_walked == 7'(DepthLvl)))
    else $error("depth limit result with wrong level count");

endmodule

bind bsp_point_locate_unit bpl_checker #(.MAX_DEPTH(MAX_DEPTH)) u_bpl_checker (.*);

`default_nettype wire

// ----- tb/bsp_point_locate_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bsp_point_locate_unit: node writes and point queries in,
// one checked result word per input word out. Depends on bpl_pkg and the block's RTL.

module bsp_point_locate_unit_tb;

  localparam int NodeCount = 8192;
  localparam int MaxDepth  = 64;

  // A pending input word. Setting drain_first holds the word back until every earlier
  // result word has come out of the block.
  typedef struct packed {
    logic              drain_first;
    bpl_pkg::in_word_t word;
  } pending_word_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  bpl_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bpl_pkg::out_word_t out_word_o;

  bsp_point_locate_unit #(
    .NODE_COUNT(NodeCount),
    .MAX_DEPTH (MaxDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // The predictor's own copy of the node memory, updated as each word is accepted.
  bpl_pkg::node_t     tree_mem [NodeCount];
  bpl_pkg::out_word_t due_results[$];

  // Stimulus side. The generator only ever points a child at a node that is already
  // written (or at the node being written), and node 0 is written first. The set of
  // written nodes is therefore closed under the child links, so no walk can reach a
  // node that was never written.
  pending_word_t   word_queue[$];
  bit              slot_written [NodeCount];
  int              written_slots[$];
  int              tree_slots[$];
  int              item_count;

  int              words_offered;
  int              words_taken;
  int              results_checked;
  int              fail_count;
  int              cycle_count;
  logic            steady;

  // A stretch of the run where neither side idles.
  assign steady = (cycle_count >= 1500) && (cycle_count < 5000);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("[bsp_point_locate_unit] ERROR");
    $finish;
  end

  // Computes the result word that the block owes for one accepted input word. A write
  // stores the node; a query walks from node 0, taking the front child when the exact
  // signed distance normal.point - dist is zero or more. Normals are Q1.15 and points
  // are Q16.16, so the distance is scaled by 2^15 to line up with the products.
  function automatic bpl_pkg::out_word_t apply_word(input bpl_pkg::in_word_t w);
    bpl_pkg::node_t               n;
    logic [bpl_pkg::NodeIdxW-1:0] at;
    int                           walked;
    longint                       d;
    bit                           done;
    bpl_pkg::out_word_t           r;
    r = '0;
    if (w.action == bpl_pkg::ActWrite) begin
      n.is_leaf     = w.is_leaf;
      n.back_child  = w.back_child;
      n.front_child = w.front_child;
      n.plane_dist  = w.plane_dist;
      n.normal_z    = w.normal_z;
      n.normal_y    = w.normal_y;
      n.normal_x    = w.normal_x;
      tree_mem[w.node_index] = n;
      r.status = bpl_pkg::StWritten;
    end else begin
      at = '0;
      walked = 0;
      done = 1'b0;
      while (!done) begin
        n = tree_mem[at];
        if (n.is_leaf) begin
          r.status     = bpl_pkg::StLeaf;
          r.leaf_index = at;
          done = 1'b1;
        end else if (walked >= MaxDepth) begin
          // The walk is cut off while still on an inner node.
          r.status = bpl_pkg::StDepth;
          done = 1'b1;
        end else begin
          d = longint'($signed(n.normal_x)) * longint'($signed(w.point_x))
            + longint'($signed(n.normal_y)) * longint'($signed(w.point_y))
            + longint'($signed(n.normal_z)) * longint'($signed(w.point_z))
            - longint'($signed(n.plane_dist)) * 64'sd32768;
          at = (d >= 0) ? n.front_child : n.back_child;
          walked++;
        end
      end
      r.levels_walked = (walked > 127) ? 7'd127 : 7'(walked);
    end
    return r;
  endfunction

  function automatic logic [bpl_pkg::NormalW-1:0] rand_normal();
    int pick;
    pick = $urandom_range(9);
    if (pick < 8) return 16'($urandom_range(65535));
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return '0;
    endcase
  endfunction

  // Coordinates and distances: full range, a small range around zero where the sign
  // of the plane distance is less lopsided, and the extremes.
  function automatic logic [bpl_pkg::CoordW-1:0] rand_coord();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return $urandom;
    if (pick < 8) return 32'($urandom_range(2097151)) - 32'd1048576;
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return 32'd1;
      default: return '1;
    endcase
  endfunction

  function automatic logic [bpl_pkg::NodeIdxW-1:0] any_written();
    return bpl_pkg::NodeIdxW'(written_slots[$urandom_range(written_slots.size() - 1)]);
  endfunction

  // Child of an inner node of the tree under construction. Favoring the newest node
  // gives long chains; an occasional link to any written node can close a loop.
  function automatic logic [bpl_pkg::NodeIdxW-1:0] pick_child();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return any_written();
    if (roll < 55) return bpl_pkg::NodeIdxW'(tree_slots[tree_slots.size() - 1]);
    return bpl_pkg::NodeIdxW'(tree_slots[$urandom_range(tree_slots.size() - 1)]);
  endfunction

  // The point fields of a write are unused, so they carry random bits.
  task automatic queue_write(input logic [bpl_pkg::NodeIdxW-1:0] idx, input logic leaf,
                             input logic [bpl_pkg::NormalW-1:0] nx,
                             input logic [bpl_pkg::NormalW-1:0] ny,
                             input logic [bpl_pkg::NormalW-1:0] nz,
                             input logic [bpl_pkg::CoordW-1:0] plane_d,
                             input logic [bpl_pkg::NodeIdxW-1:0] front,
                             input logic [bpl_pkg::NodeIdxW-1:0] back, input logic drain);
    pending_word_t p;
    p.drain_first      = drain;
    p.word.action      = bpl_pkg::ActWrite;
    p.word.node_index  = idx;
    p.word.is_leaf     = leaf;
    p.word.normal_x    = nx;
    p.word.normal_y    = ny;
    p.word.normal_z    = nz;
    p.word.plane_dist  = plane_d;
    p.word.front_child = front;
    p.word.back_child  = back;
    p.word.point_x     = $urandom;
    p.word.point_y     = $urandom;
    p.word.point_z     = $urandom;
    word_queue.push_back(p);
    if (!slot_written[idx]) begin
      slot_written[idx] = 1'b1;
      written_slots.push_back(int'(idx));
    end
    item_count++;
  endtask

  // The node fields of a query are unused, so they carry random bits.
  task automatic queue_locate(input logic [bpl_pkg::CoordW-1:0] px,
                              input logic [bpl_pkg::CoordW-1:0] py,
                              input logic [bpl_pkg::CoordW-1:0] pz, input logic drain);
    pending_word_t p;
    p.drain_first      = drain;
    p.word.action      = bpl_pkg::ActLocate;
    p.word.node_index  = bpl_pkg::NodeIdxW'($urandom);
    p.word.is_leaf     = 1'($urandom);
    p.word.normal_x    = bpl_pkg::NormalW'($urandom);
    p.word.normal_y    = bpl_pkg::NormalW'($urandom);
    p.word.normal_z    = bpl_pkg::NormalW'($urandom);
    p.word.plane_dist  = $urandom;
    p.word.front_child = bpl_pkg::NodeIdxW'($urandom);
    p.word.back_child  = bpl_pkg::NodeIdxW'($urandom);
    p.word.point_x     = px;
    p.word.point_y     = py;
    p.word.point_z     = pz;
    word_queue.push_back(p);
    item_count++;
  endtask

  // Builds a tree bottom up: a few leaves, then inner nodes whose children are nodes
  // already built, and finally a new root at node 0.
  task automatic build_tree(input int inner_nodes);
    logic [bpl_pkg::NodeIdxW-1:0] idx;
    int                           leaves;
    tree_slots.delete();
    leaves = 1 + $urandom_range(2);
    for (int i = 0; i < leaves; i++) begin
      idx = bpl_pkg::NodeIdxW'($urandom_range(NodeCount - 1, 1));
      queue_write(idx, 1'b1, rand_normal(), rand_normal(), rand_normal(), rand_coord(),
                  bpl_pkg::NodeIdxW'($urandom), bpl_pkg::NodeIdxW'($urandom), 1'b0);
      tree_slots.push_back(int'(idx));
    end
    for (int i = 0; i < inner_nodes; i++) begin
      idx = bpl_pkg::NodeIdxW'($urandom_range(NodeCount - 1, 1));
      queue_write(idx, 1'b0, rand_normal(), rand_normal(), rand_normal(), rand_coord(),
                  pick_child(), pick_child(), 1'b0);
      tree_slots.push_back(int'(idx));
    end
    queue_write('0, 1'b0, rand_normal(), rand_normal(), rand_normal(), rand_coord(),
                pick_child(), pick_child(), 1'b0);
  endtask

  // Driver. Inputs change at the falling edge. A new word is put up only once the
  // previous one has been taken, so a stalled word never changes.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || words_taken == words_offered) begin
        if (word_queue.size() != 0
            && !(word_queue[0].drain_first && results_checked != words_taken)
            && (steady || $urandom_range(99) >= 16)) begin
          in_word_i  <= word_queue[0].word;
          in_valid_i <= 1'b1;
          void'(word_queue.pop_front());
          words_offered++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < 16);
    end
  end

  // Monitor. At the rising edge an accepted input word gets its result predicted, and
  // an accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    bpl_pkg::out_word_t want;
    cycle_count++;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due_results.push_back(apply_word(in_word_i));
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with none pending: expected nothing, got %p",
                   $time, out_word_o);
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (out_word_o.status !== want.status) begin
            fail_count++;
            $display("%0t ns: status expected %0d, got %0d",
                     $time, want.status, out_word_o.status);
          end
          if (out_word_o.leaf_index !== want.leaf_index) begin
            fail_count++;
            $display("%0t ns: leaf_index expected %0d, got %0d",
                     $time, want.leaf_index, out_word_o.leaf_index);
          end
          if (out_word_o.levels_walked !== want.levels_walked) begin
            fail_count++;
            $display("%0t ns: levels_walked expected %0d, got %0d",
                     $time, want.levels_walked, out_word_o.levels_walked);
          end
        end
      end
    end
  end

  initial begin
    int sel;
    int queries;

    // Directed words. Node 0 is written before any query.
    // A leaf ignores its plane and children, so those carry the extremes here.
    queue_write('0, 1'b1, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000,
                '1, '1, 1'b0);
    queue_locate(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    queue_write('1, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff,
                '0, '0, 1'b0);
    queue_write(13'd1, 1'b1, '0, '0, '0, '0, '0, '0, 1'b0);
    // Half-unit normal along x with distance 1000: a point exactly on the plane has
    // x equal to 2000 and goes to the front child.
    queue_write('0, 1'b0, 16'h4000, '0, '0, 32'd1000, '1, 13'd1, 1'b0);
    queue_locate(32'd2000, $urandom, $urandom, 1'b0);
    queue_locate(32'd1999, '0, '0, 1'b0);
    queue_locate(32'd2001, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    // Most negative normal with the largest distance under a zero plane at the root,
    // which always takes the front child.
    queue_write(13'd2, 1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h7fff_ffff,
                '1, 13'd1, 1'b0);
    queue_write('0, 1'b0, '0, '0, '0, '0, 13'd2, 13'd1, 1'b0);
    queue_locate(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_locate(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    // A node that loops onto itself runs into the depth cap. The query waits until
    // the block has drained.
    queue_write(13'd3, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 32'h8000_0000,
                13'd3, 13'd3, 1'b0);
    queue_write('0, 1'b0, '0, '0, '0, '0, 13'd3, 13'd3, 1'b0);
    queue_locate($urandom, $urandom, $urandom, 1'b1);
    // Smallest distances either side of zero with a zero normal.
    queue_write('0, 1'b0, '0, '0, '0, 32'd1, 13'd3, '1, 1'b0);
    queue_locate($urandom, $urandom, $urandom, 1'b0);
    queue_write('0, 1'b0, '0, '0, '0, '1, '1, 13'd3, 1'b0);
    queue_locate($urandom, $urandom, $urandom, 1'b0);

    // Random part: mostly fresh trees followed by queries into them, with some stray
    // node writes in between and a few deep trees.
    while (item_count < 400) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        queue_write(bpl_pkg::NodeIdxW'($urandom), 1'($urandom), rand_normal(),
                    rand_normal(), rand_normal(), rand_coord(), any_written(),
                    any_written(), 1'($urandom_range(9) == 0));
      end else begin
        build_tree((sel < 13) ? 20 + $urandom_range(15) : $urandom_range(8, 1));
        queries = $urandom_range(8, 2);
        for (int q = 0; q < queries; q++) begin
          queue_locate(rand_coord(), rand_coord(), rand_coord(),
                       1'(q == 0 && $urandom_range(9) == 0));
        end
      end
    end

    // Hold reset, then release it away from the rising edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_queue.size() != 0 || words_taken != words_offered
           || results_checked != words_taken) begin
      @(posedge clk_i);
    end
    // Longer than the slowest walk, so any stray extra result word shows up.
    repeat (400) @(posedge clk_i);

    if (due_results.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d result words expected, got none",
               $time, due_results.size());
    end
    if (fail_count == 0) begin
      $display("[bsp_point_locate_unit] OK");
    end else begin
      $display("[bsp_point_locate_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- bsp_point_locate_unit.f -----
src/bpl_pkg.sv
src/bpl_plane_eval.sv
src/bsp_point_locate_unit.sv
src/bpl_checker.sv
tb/bsp_point_locate_unit_tb.sv
